// ----- hw/rtl/ipv_pkg.sv -----
// ----------------------------------------------------------------------------
// Involution pairing validator package
// Shared entry type, field widths and status codes.
// ----------------------------------------------------------------------------
package ipv_pkg;

    localparam int LabelW = 7;
    localparam int PosW   = 7;
    localparam int CountW = 8;
    localparam int StatW  = 3;
    localparam int UseW   = 2;

    localparam logic [StatW-1:0] ST_OK       = 3'd0;
    localparam logic [StatW-1:0] ST_RANGE    = 3'd1;
    localparam logic [StatW-1:0] ST_TRIPLE   = 3'd2;
    localparam logic [StatW-1:0] ST_INVOL    = 3'd3;
    localparam logic [StatW-1:0] ST_MISMATCH = 3'd4;
    localparam logic [StatW-1:0] ST_COUNT    = 3'd5;

    // One stored entry: its label and the position of its twin.
    typedef struct packed {
        logic [LabelW-1:0] label;
        logic [PosW-1:0]   twin;
    } t_entry;

endpackage

// ----- hw/rtl/involution_pairing_validator_top.sv -----
// ----------------------------------------------------------------------------
// Involution pairing validator
// Loads 2n entries and then checks that their twin positions form a
// fixed-point-free involution that pairs equal labels.
// ----------------------------------------------------------------------------
// A closing word with a bad entry count registers its result word in the cycle
// after it is taken; otherwise a check pass steps through RD0, RD1 and EVAL for
// each checked position, stopping at the first failure or the last position,
// and its result word is registered once the output is free. No input is taken
// during a check pass.
// Reset: label_count returns to 1, the entry counter to 0, the output empty.
module involution_pairing_validator_top #(
    parameter int MAX_LABELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: label_count.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    // Input stream: tdata = label [6:0], twin_position [13:7], zero [15:14].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Result stream: tdata = status [2:0], fail_position [9:3], zero [15:10].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata
);
    import ipv_pkg::*;

    // The entry memory holds two entries per label; the use counters hold
    // one counter per label.
    localparam int DEPTH = 2 * MAX_LABELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int UAW   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

    // Sequencer states. LOAD takes words; a check pass loops through
    // RD0 (read the entry), RD1 (read its twin and its label's use counter)
    // and EVAL (decide, bump the counter, advance).
    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_RD0  = 2'd1;
    localparam logic [1:0] S_RD1  = 2'd2;
    localparam logic [1:0] S_EVAL = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [LabelW-1:0] r_n;
    logic [CountW-1:0] r_count, n_count;
    logic [CountW-1:0] r_pos, n_pos;
    logic [CountW-1:0] r_span, n_span;
    logic              r_out_valid, n_out_valid;
    logic [StatW-1:0]  r_out_status, n_out_status;
    logic [PosW-1:0]   r_out_fail, n_out_fail;

    logic              in_acc;
    logic              out_free;
    logic [CountW-1:0] total;
    logic              count_bad;
    t_entry            wr_entry;
    t_entry            ent_i;
    t_entry            ent_tw;
    logic              st_wr_en;
    logic [AW-1:0]     st_wr_addr;

    // Use counter memory: cleared entry by entry while a load runs, so every
    // label below n is zero by the time a full-length load closes.
    logic [UseW-1:0]   r_uses [MAX_LABELS];
    logic [UseW-1:0]   r_uses_q;
    logic              uses_wr_en;
    logic [UAW-1:0]    uses_wr_addr;
    logic [UseW-1:0]   uses_wr_data;

    logic [StatW-1:0]  eval_st;
    logic              eval_last;
    logic              eval_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= LabelW'(1);
        end else if (i_cfg_valid) begin
            r_n <= i_cfg_data;
        end
    end

    // A result word may be replaced in the cycle that it is taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign total     = (r_count == {CountW{1'b1}}) ? r_count : r_count + CountW'(1);
    assign count_bad = (r_n == '0) || (32'(r_n) > MAX_LABELS) ||
                       (total != {r_n, 1'b0});

    assign wr_entry.label = s_axis_tdata[6:0];
    assign wr_entry.twin  = s_axis_tdata[13:7];
    assign st_wr_en       = in_acc && (32'(r_count) < DEPTH);
    assign st_wr_addr     = AW'(r_count);

    ipv_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (st_wr_en),
        .i_wr_addr  (st_wr_addr),
        .i_wr_data  (wr_entry),
        .i_rda_en   (r_state == S_RD0),
        .i_rda_addr (AW'(r_pos)),
        .o_rda_data (ent_i),
        .i_rdb_en   (r_state == S_RD1),
        .i_rdb_addr (AW'(ent_i.twin)),
        .o_rdb_data (ent_tw)
    );

    // Decision for the current position, in the order the checks take
    // precedence: label range, third use, involution, label match.
    always_comb begin
        if (ent_i.label >= r_n) begin
            eval_st = ST_RANGE;
        end else if (r_uses_q >= UseW'(2)) begin
            eval_st = ST_TRIPLE;
        end else if (({1'b0, ent_i.twin} == r_pos) || ({1'b0, ent_i.twin} >= r_span) ||
                     ({1'b0, ent_tw.twin} != r_pos)) begin
            eval_st = ST_INVOL;
        end else if (ent_tw.label != ent_i.label) begin
            eval_st = ST_MISMATCH;
        end else begin
            eval_st = ST_OK;
        end
    end

    assign eval_last = (r_pos == r_span - CountW'(1));
    assign eval_done = (eval_st != ST_OK) || eval_last;

    always_comb begin
        uses_wr_en   = 1'b0;
        uses_wr_addr = UAW'(ent_i.label);
        uses_wr_data = r_uses_q + UseW'(1);
        if (in_acc) begin
            uses_wr_en   = (32'(r_count) < MAX_LABELS);
            uses_wr_addr = UAW'(r_count);
            uses_wr_data = '0;
        end else if ((r_state == S_EVAL) && !eval_done) begin
            uses_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uses_wr_en) begin
            r_uses[uses_wr_addr] <= uses_wr_data;
        end
        if (r_state == S_RD1) begin
            r_uses_q <= r_uses[UAW'(ent_i.label)];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_span       = r_span;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_fail   = r_out_fail;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (!s_axis_tlast) begin
                        n_count = total;
                    end else begin
                        n_count = '0;
                        if (count_bad) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_COUNT;
                            n_out_fail   = '0;
                        end else begin
                            n_pos   = '0;
                            n_span  = {r_n, 1'b0};
                            n_state = S_RD0;
                        end
                    end
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!eval_done) begin
                    n_pos   = r_pos + CountW'(1);
                    n_state = S_RD0;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = eval_st;
                    n_out_fail   = (eval_st == ST_OK) ? '0 : r_pos[PosW-1:0];
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_span       <= n_span;
        r_out_status <= n_out_status;
        r_out_fail   <= n_out_fail;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_fail, r_out_status};

    // A result word is only produced by a closing input word or at the end
    // of a check pass.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EVAL || (in_acc && s_axis_tlast)))
        else $error("result word appeared without a source");

    // A check pass never walks beyond the span of the load.
    a_pos_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_pos < r_span))
        else $error("check position beyond span");

    // A check pass only starts for a label count the memories can hold.
    a_check_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> ((r_n != '0) && (32'(r_n) <= MAX_LABELS)))
        else $error("check pass with unusable label count");

    // Passing and count results carry no failing position.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_status == ST_OK) || (r_out_status == ST_COUNT)))
            |-> (r_out_fail == '0))
        else $error("nonzero failing position on pass or count result");

endmodule

// ----- hw/rtl/ipv_store.sv -----
// ----------------------------------------------------------------------------
// Entry store
// Label and twin memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ipv_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  ipv_pkg::t_entry i_wr_data,
    input  logic            i_rda_en,
    input  logic [AW-1:0]   i_rda_addr,
    output ipv_pkg::t_entry o_rda_data,
    input  logic            i_rdb_en,
    input  logic [AW-1:0]   i_rdb_addr,
    output ipv_pkg::t_entry o_rdb_data
);
    import ipv_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rda;
    t_entry r_rdb;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data only changes when a read is requested, so it holds while
    // the sequencer waits.
    always_ff @(posedge i_clk) begin
        if (i_rda_en) begin
            r_rda <= r_mem[i_rda_addr];
        end
        if (i_rdb_en) begin
            r_rdb <= r_mem[i_rdb_addr];
        end
    end

    assign o_rda_data = r_rda;
    assign o_rdb_data = r_rdb;

endmodule

// ----- verif/involution_pairing_validator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Involution pairing validator testbench
// Streams entry loads into the validator under several label counts and
// compares each result word against a predictor that checks every load.
// ----------------------------------------------------------------------------
module involution_pairing_validator_top_tb;

    import ipv_pkg::*;

    localparam int MAX_LABELS  = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int WORD_GOAL   = 1950;
    localparam int HOLD_CYCLES = 300;

    // Shapes of one load: a good pairing, a pairing with one defect, or noise.
    typedef enum int {
        LD_GOOD, LD_RANGE, LD_RELABEL, LD_SELF, LD_FAR, LD_SCRAMBLE,
        LD_SHORT, LD_LONG, LD_NOISE, LD_OVERLONG, LD_FULLSPAN
    } t_load_kind;

    typedef struct {
        logic [LabelW-1:0] label;
        logic [PosW-1:0]   twin;
        logic              last;
    } t_entry_word;

    typedef struct {
        logic [StatW-1:0] status;
        logic [PosW-1:0]  fail_pos;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // Words waiting to be sent and verdicts waiting to be seen.
    t_entry_word pending_entries[$];
    t_verdict    expected_verdicts[$];
    t_entry_word cur_word;
    bit          word_out = 1'b0;
    int          words_queued = 0;
    int          fault_cnt = 0;
    int          cycle_cnt = 0;

    // Shared pacing controls: calm turns off random idling on both sides,
    // hold_left makes the receiver stall until it counts down to zero.
    bit          calm = 1'b0;
    int          hold_left = 0;

    // Predictor copy of the block state.
    int          cfg_labels = 1;
    int          load_pos = 0;
    logic [LabelW-1:0] held_label [2*MAX_LABELS];
    logic [PosW-1:0]   held_twin  [2*MAX_LABELS];

    involution_pairing_validator_top #(
        .MAX_LABELS(MAX_LABELS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // label [6:0], twin [13:7], zero [15:14]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // status [2:0], fail_position [9:3]
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The run ends as a failure if it drags on far past any correct run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // Sender. A word stays on the bus until it is taken; between words the
    // sender idles at random unless the calm stretch is running.
    always @(negedge i_clk) begin
        if (!word_out) begin
            if (pending_entries.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
                cur_word = pending_entries.pop_front();
                word_out = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, cur_word.twin, cur_word.label};
                s_axis_tlast  <= cur_word.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. A long hold-off lets the block back up into its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
        end
    end

    // Predictor. Each accepted word is stored at the load position; the word
    // with tlast closes the load and the whole load is judged in order.
    always @(posedge i_clk) begin : predict_load
        int pos;
        int total;
        int span;
        int lab;
        int tw;
        logic [UseW-1:0] uses [MAX_LABELS];
        t_verdict v;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pos = load_pos;
            if (pos < 2 * MAX_LABELS) begin
                held_label[pos] = cur_word.label;
                held_twin[pos]  = cur_word.twin;
            end
            // The entry counter saturates, so an overlong load never matches.
            total = (pos < 255) ? pos + 1 : 255;
            load_pos = cur_word.last ? 0 : total;
            if (cur_word.last) begin
                span = 2 * cfg_labels;
                v.status = ST_OK;
                v.fail_pos = '0;
                if (cfg_labels == 0 || cfg_labels > MAX_LABELS || total != span) begin
                    v.status = ST_COUNT;
                end else begin
                    for (int k = 0; k < MAX_LABELS; k++) uses[k] = '0;
                    for (int i = 0; i < span && v.status == ST_OK; i++) begin
                        lab = held_label[i];
                        tw  = held_twin[i];
                        if (lab >= cfg_labels) begin
                            v.status = ST_RANGE;
                        end else if (uses[lab] >= 2) begin
                            v.status = ST_TRIPLE;
                        end else begin
                            uses[lab]++;
                            // The twin must be another in-range entry that
                            // points back and carries the same label.
                            if (tw == i || tw >= span || held_twin[tw] != i) begin
                                v.status = ST_INVOL;
                            end else if (held_label[tw] != lab) begin
                                v.status = ST_MISMATCH;
                            end
                        end
                        if (v.status != ST_OK) v.fail_pos = 7'(i);
                    end
                end
                expected_verdicts.push_back(v);
            end
            word_out = 1'b0;
        end
    end

    // Monitor. Every result word must match the oldest waiting verdict.
    always @(posedge i_clk) begin : check_result
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d position %0d",
                         $time, m_axis_tdata[2:0], m_axis_tdata[9:3]);
                fault_cnt++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[2:0] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_axis_tdata[2:0]);
                    fault_cnt++;
                end
                if (m_axis_tdata[9:3] !== want.fail_pos) begin
                    $display("%0t: fail position mismatch, expected %0d, got %0d",
                             $time, want.fail_pos, m_axis_tdata[9:3]);
                    fault_cnt++;
                end
            end
        end
    end

    task automatic push_word(input int label, input int twin, input bit last);
        t_entry_word w;
        w.label = 7'(label);
        w.twin  = 7'(twin);
        w.last  = last;
        pending_entries.push_back(w);
        words_queued++;
    endtask

    // Writes the label count; only called while the block is idle.
    task automatic write_labels(input int n);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 7'(n);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_labels = n;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every word is sent and every verdict has been seen, then
    // lets a check pass worth of cycles go by.
    task automatic await_quiet();
        do @(posedge i_clk);
        while (pending_entries.size() != 0 || word_out || expected_verdicts.size() != 0);
        repeat (6 * MAX_LABELS + 8) @(posedge i_clk);
    endtask

    // Builds one load of the given kind for label count n.
    task automatic queue_load(input int n, input t_load_kind kind);
        int lbl [300];
        int tw [300];
        int pos [2*MAX_LABELS];
        int lab_perm [MAX_LABELS];
        int span;
        int len;
        int j;
        int t;
        bit legal;
        span  = 2 * n;
        len   = span;
        legal = (n >= 1 && n <= MAX_LABELS);
        if (legal) begin
            // Random fixed-point-free pairing; each pair gets its own label.
            for (j = 0; j < span; j++) pos[j] = j;
            for (j = span - 1; j > 0; j--) begin
                t = $urandom_range(0, j);
                {pos[j], pos[t]} = {pos[t], pos[j]};
            end
            for (j = 0; j < n; j++) lab_perm[j] = j;
            for (j = n - 1; j > 0; j--) begin
                t = $urandom_range(0, j);
                {lab_perm[j], lab_perm[t]} = {lab_perm[t], lab_perm[j]};
            end
            for (j = 0; j < n; j++) begin
                tw[pos[2*j]]    = pos[2*j+1];
                tw[pos[2*j+1]]  = pos[2*j];
                lbl[pos[2*j]]   = lab_perm[j];
                lbl[pos[2*j+1]] = lab_perm[j];
            end
        end
        t = (span > 0) ? $urandom_range(0, span - 1) : 0;
        case (kind)
            LD_RANGE:    lbl[t] = $urandom_range(n, 127);
            LD_RELABEL:  lbl[t] = $urandom_range(0, n - 1);
            LD_SELF:     tw[t] = t;
            LD_FAR:      tw[t] = (span <= 127) ? $urandom_range(span, 127) : 127;
            LD_SCRAMBLE: tw[t] = $urandom_range(0, 127);
            LD_SHORT:    len = $urandom_range(1, span - 1);
            LD_LONG: begin
                len = span + $urandom_range(1, 3);
                for (j = span; j < len; j++) begin
                    lbl[j] = $urandom_range(0, 127);
                    tw[j]  = $urandom_range(0, 127);
                end
            end
            LD_NOISE, LD_OVERLONG, LD_FULLSPAN: begin
                if (kind == LD_OVERLONG) len = 260;
                else if (kind == LD_FULLSPAN) len = (span > 0) ? span : 1;
                else len = $urandom_range(1, 2 * (legal ? n : 3) + 2);
                for (j = 0; j < len; j++) begin
                    lbl[j] = $urandom_range(0, 127);
                    tw[j]  = $urandom_range(0, 127);
                end
            end
            default: ;
        endcase
        for (j = 0; j < len; j++) push_word(lbl[j], tw[j], j == len - 1);
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int loads;
        int r;
        t_load_kind kind;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed loads at one label: a good pair, a label equal to n, a twin
        // pointing at itself, a twin beyond the span, and short loads.
        write_labels(1);
        push_word(0, 1, 0);   push_word(0, 0, 1);
        push_word(1, 1, 0);   push_word(0, 0, 1);
        push_word(0, 0, 0);   push_word(0, 0, 1);
        push_word(0, 127, 0); push_word(0, 0, 1);
        push_word(0, 1, 1);
        push_word(127, 127, 1);
        await_quiet();

        // Two labels: a label used a third time, a pair with unequal labels,
        // and a twin that does not point back.
        write_labels(2);
        push_word(0, 1, 0); push_word(0, 0, 0); push_word(0, 3, 0); push_word(0, 2, 1);
        push_word(0, 1, 0); push_word(1, 0, 0); push_word(1, 3, 0); push_word(1, 2, 1);
        push_word(0, 1, 0); push_word(0, 2, 0); push_word(1, 3, 0); push_word(1, 2, 1);
        await_quiet();

        phase = 0;
        while (words_queued < WORD_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 60) n = $urandom_range(1, 6);
            else if (r < 85) n = $urandom_range(7, 24);
            else if (r < 93) n = $urandom_range(25, 64);
            else if (r < 97) n = MAX_LABELS;
            else if (r < 99) n = 1;
            else n = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
            // Early phases cover the extremes and the pacing corner cases.
            case (phase)
                0: n = MAX_LABELS;
                1: n = 127;
                2: n = 0;
                3: n = 4;
                4: n = 1;
                5: n = 3;
                default: ;
            endcase
            calm = (phase == 3);
            write_labels(n);
            if (phase == 4) begin
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
            end

            if (n <= 8) loads = $urandom_range(3, 10);
            else if (n <= 24) loads = $urandom_range(2, 4);
            else loads = $urandom_range(1, 2);
            if (phase == 4) loads = 30;

            if (n < 1 || n > MAX_LABELS) begin
                // Count errors only; one load exactly 2n long for the big count of phase 1.
                if (n > MAX_LABELS && phase == 1) queue_load(n, LD_FULLSPAN);
                for (int l = 0; l < $urandom_range(2, 4); l++) queue_load(n, LD_NOISE);
            end else begin
                if (phase == 5) queue_load(n, LD_OVERLONG);
                for (int l = 0; l < loads; l++) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) kind = LD_GOOD;
                    else if (r < 58) kind = LD_RANGE;
                    else if (r < 68) kind = LD_RELABEL;
                    else if (r < 74) kind = LD_SELF;
                    else if (r < 79) kind = LD_FAR;
                    else if (r < 86) kind = LD_SCRAMBLE;
                    else if (r < 91) kind = LD_SHORT;
                    else if (r < 95) kind = LD_LONG;
                    else kind = LD_NOISE;
                    queue_load(n, kind);
                end
            end
            await_quiet();
            phase++;
        end

        calm = 1'b0;
        await_quiet();
        if (fault_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- involution_pairing_validator_top.f -----
hw/rtl/ipv_pkg.sv
hw/rtl/ipv_store.sv
hw/rtl/involution_pairing_validator_top.sv
verif/involution_pairing_validator_top_tb.sv
